### src/imuf_pkg.sv
// Shared types and constants of the inertial sensor frame parser.
`default_nettype none
package imuf_pkg;

	// Configuration register indexes
	localparam logic REG_SYNC_BYTE = 1'b0;
	localparam logic REG_TYPE_MASK = 1'b1;

	localparam logic [7:0] SYNC_RESET = 8'h55;
	localparam logic [7:0] MASK_RESET = 8'h50;

	// Result status codes
	localparam logic STATUS_ACCEPT = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Data bytes of a frame: bytes 2 to 9
	localparam int NUM_DATA_BYTES = 8;

	typedef logic [NUM_DATA_BYTES-1:0][7:0] data_bytes_t;

	// Window summary seen by the frame check
	typedef struct packed {
		logic       full;
		logic [7:0] sum;
		logic [7:0] first;
		logic [7:0] ftype;
	} win_stat_t;

endpackage
`default_nettype wire

### src/imu_serial_frame_parser.sv
// Top level of the byte-serial inertial sensor frame parser.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | rx_byte
//  out      | out_valid/ out_ready | status, frame_type, word_zero..word_three
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// One word per cycle while in_ready is high: the checks run on the registered window plus
// the new word and land in a single output register in the cycle after acceptance.
// in_ready drops only while a result sits in the output register and
// out_ready is low. Reset clears fill count, checksum and output valid, and
// restores the sync byte and type mask to their defaults.
`default_nettype none
module imu_serial_frame_parser #(
	parameter int FRAME_LEN = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    status,
	output logic [7:0]              frame_type,
	output logic signed [15:0]      word_zero,
	output logic signed [15:0]      word_one,
	output logic signed [15:0]      word_two,
	output logic signed [15:0]      word_three,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data
);

	localparam int HOLD_LEN = FRAME_LEN - 1;

	logic                  in_fire;
	logic                  frame_ok;
	logic [7:0]            sync_q;
	logic [7:0]            mask_q;
	logic                  out_valid_q;
	imuf_pkg::win_stat_t   win;
	imuf_pkg::data_bytes_t data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= imuf_pkg::SYNC_RESET;
			mask_q <= imuf_pkg::MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				imuf_pkg::REG_SYNC_BYTE: sync_q <= cfg_data;
				imuf_pkg::REG_TYPE_MASK: mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Check sync, type mask and checksum against the closing word
	assign frame_ok = (win.first == sync_q) &&
	                  ((win.ftype & mask_q) == mask_q) &&
	                  (win.sum == rx_byte);

	imuf_window #(
		.HOLD_LEN(HOLD_LEN)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_fire),
		.clr     (win.full && frame_ok),
		.rx_byte (rx_byte),
		.stat    (win),
		.data    (data)
	);

	// Output valid: load on a closing word, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= win.full;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; rejected windows carry zero words
	always_ff @(posedge clk) begin
		if (in_fire && win.full) begin
			frame_type <= win.ftype;
			if (frame_ok) begin
				status     <= imuf_pkg::STATUS_ACCEPT;
				word_zero  <= {data[1], data[0]};
				word_one   <= {data[3], data[2]};
				word_two   <= {data[5], data[4]};
				word_three <= {data[7], data[6]};
			end else begin
				status     <= imuf_pkg::STATUS_REJECT;
				word_zero  <= '0;
				word_one   <= '0;
				word_two   <= '0;
				word_three <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A word that only fills the window leaves no result behind
	a_fill_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !win.full |=> !out_valid)
		else $error("result produced while window filling");

	// A closing word always yields a result
	a_close_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && win.full |=> out_valid)
		else $error("closing word produced no result");

	// An accepted frame empties the window
	a_accept_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && win.full && frame_ok |=> !win.full)
		else $error("window not cleared after accepted frame");

	// A reject keeps the window full
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && win.full && !frame_ok |=> win.full)
		else $error("window lost fill after reject");

	// Rejected results carry zero data words
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == imuf_pkg::STATUS_REJECT |->
		word_zero == 16'sd0 && word_one == 16'sd0 &&
		word_two == 16'sd0 && word_three == 16'sd0)
		else $error("rejected result has nonzero words");

endmodule
`default_nettype wire

### src/imuf_window.sv
// Byte window of the frame parser: shift line, fill count and running checksum.
`default_nettype none
module imuf_window #(
	parameter int HOLD_LEN = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic                  clr,
	input  wire logic [7:0]            rx_byte,
	output imuf_pkg::win_stat_t        stat,
	output imuf_pkg::data_bytes_t      data
);

	localparam int CNT_W = $clog2(HOLD_LEN + 1);

	logic [7:0]       sh_q [HOLD_LEN];
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             full;

	assign full = (cnt_q == CNT_W'(HOLD_LEN));

	// Shift every accepted word in at the newest end; oldest sits at index 0
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < HOLD_LEN - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
			sh_q[HOLD_LEN-1] <= rx_byte;
		end
	end

	// Track fill level and the 8-bit sum of the held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (push) begin
			if (clr) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else if (full) begin
				sum_q <= sum_q - sh_q[0] + rx_byte;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	assign stat.full  = full;
	assign stat.sum   = sum_q;
	assign stat.first = sh_q[0];
	assign stat.ftype = sh_q[1];

	// Data bytes at or past the checksum position read as zero on short frames
	for (genvar k = 0; k < imuf_pkg::NUM_DATA_BYTES; k++) begin : g_data
		if (k + 2 < HOLD_LEN) begin : g_held
			assign data[k] = sh_q[k+2];
		end else begin : g_zero
			assign data[k] = '0;
		end
	end

endmodule
`default_nettype wire
